FILE: sv/dbts_pkg.sv
// ----------------------------------------------------------------------------
// dbts_pkg
// Shared types, register codes and the angle-to-pulse table for the
// debounced toggle servo position block.
// ----------------------------------------------------------------------------
package dbts_pkg;

    // Configuration port widths and register indexes
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOCKOUT  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OPEN     = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOSED   = 8'd3;

    // Reset values of the configuration registers
    localparam logic [15:0] DEBOUNCE_RST = 16'd8;
    localparam logic [15:0] LOCKOUT_RST  = 16'd50;
    localparam logic [7:0]  OPEN_RST     = 8'd90;
    localparam logic [7:0]  CLOSED_RST   = 8'd0;

    // Tick counters saturate here
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // Servo timing constants
    localparam int          PULSE_MIN_US = 500;
    localparam int          PULSE_MAX_US = 2500;
    localparam int          ANGLE_MAX    = 180;
    localparam logic [7:0]  ANGLE_CLAMP  = 8'd180;
    localparam int          PULSE_W      = 12;

    // 20000 us period splits into a shift by 5 and a divide by 625
    localparam int PERIOD_SHIFT = 5;
    localparam int PERIOD_ODD   = 625;

    // Pulse width in us for every angle from 0 to 180 degrees
    typedef logic [ANGLE_MAX:0][PULSE_W-1:0] pulse_tbl_t;

    function automatic pulse_tbl_t build_pulse_tbl();
        pulse_tbl_t tbl;
        for (int i = 0; i <= ANGLE_MAX; i++)
        begin
            tbl[i] = PULSE_W'(PULSE_MIN_US + ((PULSE_MAX_US - PULSE_MIN_US) * i) / ANGLE_MAX);
        end
        return tbl;
    endfunction

    localparam pulse_tbl_t PULSE_TBL = build_pulse_tbl();

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIX
    } dbts_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // take a sample and update the debounce state
        logic advance;   // run the reciprocal multiply
        logic out_load;  // correct the quotient and fill the result register
    } dbts_cmd_t;

endpackage

FILE: sv/debounced_toggle_servo_position.sv
// ----------------------------------------------------------------------------
// debounced_toggle_servo_position
// Debounces a sampled push button and toggles a servo between two angles,
// reporting the PWM duty count of the current position on every sample.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one sample tick of the raw button
// level, and each sample produces exactly one result. A sample passes through
// the stage 1 register and the stage 2 register into the output register;
// the block takes no new sample until its previous result is being loaded,
// paced by the reciprocal multiply and quotient correction stages of the duty scaling.
// The result register holds a finished result while the next sample is
// already in work; if results are not taken, the pipeline stalls in its last
// stage. Configuration writes are taken in any cycle (cfg_ready is always
// high) and are meant to happen only while no sample is in work. Register 0
// is the debounce length, 1 the lockout length, 2 the open angle and 3 the
// closed angle; other indexes are ignored. Angles above 180 degrees are
// clamped, and the duty width follows DUTY_BITS.
// ----------------------------------------------------------------------------
module debounced_toggle_servo_position #(
    parameter int DUTY_BITS = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              button_level,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              position_open,
    output logic [DUTY_BITS-1:0]              duty_value,
    output logic                              stable_pressed,
    output logic                              toggled,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dbts_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [dbts_pkg::CFG_DATA_W-1:0]   cfg_data
);

    dbts_pkg::dbts_cmd_t cmd;

    // Accept configuration writes at once
    assign cfg_ready = 1'b1;

    dbts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    dbts_dpath #(
        .DUTY_BITS (DUTY_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .button_level   (button_level),
        .cfg_we         (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .position_open  (position_open),
        .duty_value     (duty_value),
        .stable_pressed (stable_pressed),
        .toggled        (toggled)
    );

endmodule

FILE: sv/dbts_ctrl.sv
// ----------------------------------------------------------------------------
// dbts_ctrl
// Sequencer for the sample pipeline and owner of the result valid flag.
// ----------------------------------------------------------------------------
module dbts_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output dbts_pkg::dbts_cmd_t cmd
);

    dbts_pkg::dbts_state_t state_reg;
    dbts_pkg::dbts_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_load;
    logic                  accept;

    // Drive commands and the input handshake
    always_comb
    begin
        out_load = (state_reg == dbts_pkg::ST_FIX) && (!out_valid_reg || out_ready);
        in_ready = (state_reg == dbts_pkg::ST_IDLE) || out_load;
        accept   = in_valid && in_ready;

        cmd.load     = accept;
        cmd.advance  = (state_reg == dbts_pkg::ST_MUL);
        cmd.out_load = out_load;

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dbts_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = dbts_pkg::ST_MUL;
                end
            end
            dbts_pkg::ST_MUL:
            begin
                state_next = dbts_pkg::ST_FIX;
            end
            dbts_pkg::ST_FIX:
            begin
                if (out_load)
                begin
                    state_next = accept ? dbts_pkg::ST_MUL : dbts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dbts_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dbts_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: sv/dbts_dpath.sv
// ----------------------------------------------------------------------------
// dbts_dpath
// Configuration registers, debounce and lockout state, and the duty
// scaling pipeline with its result register.
// ----------------------------------------------------------------------------
module dbts_dpath #(
    parameter int DUTY_BITS = 14
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dbts_pkg::dbts_cmd_t                 cmd,
    input  logic                                button_level,
    input  logic                                cfg_we,
    input  logic [dbts_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dbts_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                position_open,
    output logic [DUTY_BITS-1:0]                duty_value,
    output logic                                stable_pressed,
    output logic                                toggled
);

    // Widths of the scaling path
    localparam int PW    = DUTY_BITS + dbts_pkg::PULSE_W;     // pulse * (2^B - 1)
    localparam int XW    = PW - dbts_pkg::PERIOD_SHIFT;        // after the shift by 5
    localparam int SHIFT = XW;
    localparam longint unsigned RECIP = (64'd1 << SHIFT) / 64'd625;
    localparam int MW    = $clog2(RECIP + 1);
    localparam int MULW  = XW + MW;

    // Configuration registers
    logic [15:0] debounce_reg;
    logic [15:0] lockout_reg;
    logic [7:0]  open_reg;
    logic [7:0]  closed_reg;

    // Debounce and lockout state
    logic        primed_reg,       primed_next;
    logic        raw_reg,          raw_next;
    logic        stable_reg,       stable_next;
    logic [15:0] since_change_reg, since_change_next;
    logic [15:0] since_toggle_reg, since_toggle_next;
    logic        is_open_reg,      is_open_next;
    logic        toggle_now;

    // Pipeline registers
    logic [XW-1:0]        x1_reg;
    logic                 open1_reg, stable1_reg, tog1_reg;
    logic [XW-1:0]        x2_reg;
    logic [DUTY_BITS-1:0] q2_reg;
    logic                 open2_reg, stable2_reg, tog2_reg;
    logic                 open_out_reg, stable_out_reg, tog_out_reg;
    logic [DUTY_BITS-1:0] duty_out_reg;

    logic [7:0]           angle;
    logic [7:0]           angle_c;
    logic [dbts_pkg::PULSE_W-1:0] pulse;
    logic [PW-1:0]        prod;
    logic [MULW-1:0]      mul_full;
    logic [MULW-1:0]      mul_shift;
    logic [XW-1:0]        back_mul;
    logic [XW-1:0]        rem;
    logic [DUTY_BITS-1:0] duty_fix;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= dbts_pkg::DEBOUNCE_RST;
            lockout_reg  <= dbts_pkg::LOCKOUT_RST;
            open_reg     <= dbts_pkg::OPEN_RST;
            closed_reg   <= dbts_pkg::CLOSED_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dbts_pkg::REG_DEBOUNCE: debounce_reg <= cfg_data;
                dbts_pkg::REG_LOCKOUT:  lockout_reg  <= cfg_data;
                dbts_pkg::REG_OPEN:     open_reg     <= cfg_data[7:0];
                dbts_pkg::REG_CLOSED:   closed_reg   <= cfg_data[7:0];
                default:                ;
            endcase
        end
    end

    // Update debounce and lockout state for one sample
    always_comb
    begin
        primed_next       = 1'b1;
        raw_next          = raw_reg;
        stable_next       = stable_reg;
        since_change_next = since_change_reg;
        since_toggle_next = since_toggle_reg;
        is_open_next      = is_open_reg;
        toggle_now        = 1'b0;
        if (!primed_reg)
        begin
            raw_next          = button_level;
            stable_next       = button_level;
            since_change_next = 16'd0;
        end
        else
        begin
            since_change_next = (since_change_reg == dbts_pkg::CNT_MAX) ?
                                since_change_reg : since_change_reg + 16'd1;
            since_toggle_next = (since_toggle_reg == dbts_pkg::CNT_MAX) ?
                                since_toggle_reg : since_toggle_reg + 16'd1;
            if (button_level != raw_reg)
            begin
                raw_next          = button_level;
                since_change_next = 16'd0;
            end
            if ((since_change_next >= debounce_reg) && (stable_reg != raw_next))
            begin
                stable_next = raw_next;
                if (raw_next && (since_toggle_next >= lockout_reg))
                begin
                    is_open_next      = ~is_open_reg;
                    since_toggle_next = 16'd0;
                    toggle_now        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg       <= 1'b0;
            raw_reg          <= 1'b0;
            stable_reg       <= 1'b0;
            since_change_reg <= 16'd0;
            since_toggle_reg <= dbts_pkg::CNT_MAX;
            is_open_reg      <= 1'b0;
        end
        else if (cmd.load)
        begin
            primed_reg       <= primed_next;
            raw_reg          <= raw_next;
            stable_reg       <= stable_next;
            since_change_reg <= since_change_next;
            since_toggle_reg <= since_toggle_next;
            is_open_reg      <= is_open_next;
        end
    end

    // Look up the pulse and scale by 2^B - 1 with a shift and subtract
    always_comb
    begin
        angle   = is_open_next ? open_reg : closed_reg;
        angle_c = (angle > dbts_pkg::ANGLE_CLAMP) ? dbts_pkg::ANGLE_CLAMP : angle;
        pulse   = dbts_pkg::PULSE_TBL[angle_c];
        prod    = (PW'(pulse) << DUTY_BITS) - PW'(pulse);
    end

    // Stage 1: capture scaled pulse and result flags
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x1_reg      <= prod[PW-1:dbts_pkg::PERIOD_SHIFT];
            open1_reg   <= is_open_next;
            stable1_reg <= stable_next;
            tog1_reg    <= toggle_now;
        end
    end

    // Stage 2: estimate the quotient by 625 with a reciprocal multiply
    assign mul_full  = MULW'(x1_reg) * MULW'(RECIP);
    assign mul_shift = mul_full >> SHIFT;

    always_ff @(posedge clk)
    begin
        if (cmd.advance)
        begin
            x2_reg      <= x1_reg;
            q2_reg      <= mul_shift[DUTY_BITS-1:0];
            open2_reg   <= open1_reg;
            stable2_reg <= stable1_reg;
            tog2_reg    <= tog1_reg;
        end
    end

    // Stage 3: the estimate is low by at most one, fix it from the remainder
    assign back_mul = XW'(q2_reg) * XW'(dbts_pkg::PERIOD_ODD);
    assign rem      = x2_reg - back_mul;
    assign duty_fix = (rem >= XW'(dbts_pkg::PERIOD_ODD)) ? q2_reg + DUTY_BITS'(1) : q2_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            duty_out_reg   <= duty_fix;
            open_out_reg   <= open2_reg;
            stable_out_reg <= stable2_reg;
            tog_out_reg    <= tog2_reg;
        end
    end

    assign position_open  = open_out_reg;
    assign duty_value     = duty_out_reg;
    assign stable_pressed = stable_out_reg;
    assign toggled        = tog_out_reg;

endmodule

FILE: tb/servo_toggle_checker.sv
// ----------------------------------------------------------------------------
// servo_toggle_checker
// Watches the sample, result and register channels of the debounced toggle
// servo position block. Keeps its own copy of the debounce, lockout and
// position state, predicts one result per accepted sample and compares every
// accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module servo_toggle_checker #(
    parameter int DUTY_BITS = 14
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             button_level,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic                             position_open,
    input  logic [DUTY_BITS-1:0]             duty_value,
    input  logic                             stable_pressed,
    input  logic                             toggled,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [dbts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dbts_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               error_count,
    output int                               outstanding,
    output int                               results_checked,
    output int                               toggles_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // Servo timing in microseconds and degrees, and the tick counter ceiling
    localparam longint unsigned PULSE_LOW_US  = 500;
    localparam longint unsigned PULSE_SPAN_US = 2000;
    localparam longint unsigned FRAME_US      = 20000;
    localparam longint unsigned ANGLE_LIMIT   = 180;
    localparam logic [15:0]     AGE_CEILING   = 16'hFFFF;

    typedef struct packed {
        logic                 position_open;
        logic [DUTY_BITS-1:0] duty_value;
        logic                 stable_pressed;
        logic                 toggled;
    } servo_result_t;

    servo_result_t expected_q[$];

    // Register copies
    logic [15:0] debounce_len;
    logic [15:0] lockout_len;
    logic [7:0]  open_deg;
    logic [7:0]  closed_deg;

    // Button and position state
    logic        seen_first;
    logic        raw_q;
    logic        stable_q;
    logic [15:0] change_age;
    logic [15:0] toggle_age;
    logic        open_q;

    function automatic logic [15:0] age_up(input logic [15:0] age);
        return (age == AGE_CEILING) ? age : age + 16'd1;
    endfunction

    function automatic logic [DUTY_BITS-1:0] duty_for_degrees(input logic [7:0] degrees);
        longint unsigned clamped;
        longint unsigned width_micros;
        longint unsigned full_scale;
        clamped      = (degrees > ANGLE_LIMIT) ? ANGLE_LIMIT : longint'(degrees);
        width_micros = PULSE_LOW_US + (PULSE_SPAN_US * clamped) / ANGLE_LIMIT;
        full_scale   = (64'd1 << DUTY_BITS) - 64'd1;
        return DUTY_BITS'((width_micros * full_scale) / FRAME_US);
    endfunction

    // Advance the button state by one sample and form its result
    function automatic servo_result_t step_servo(input logic sample);
        servo_result_t res;
        res.toggled = 1'b0;
        if (!seen_first)
        begin
            seen_first = 1'b1;
            raw_q      = sample;
            stable_q   = sample;
            change_age = '0;
        end
        else
        begin
            change_age = age_up(change_age);
            toggle_age = age_up(toggle_age);
            if (sample != raw_q)
            begin
                raw_q      = sample;
                change_age = '0;
            end
            if (change_age >= debounce_len && stable_q != raw_q)
            begin
                stable_q = raw_q;
                if (stable_q && toggle_age >= lockout_len)
                begin
                    open_q      = ~open_q;
                    toggle_age  = '0;
                    res.toggled = 1'b1;
                end
            end
        end
        res.position_open  = open_q;
        res.duty_value     = duty_for_degrees(open_q ? open_deg : closed_deg);
        res.stable_pressed = stable_q;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        servo_result_t want;
        servo_result_t got;
        if (!rst_n)
        begin
            expected_q.delete();
            debounce_len    = 16'd8;
            lockout_len     = 16'd50;
            open_deg        = 8'd90;
            closed_deg      = 8'd0;
            seen_first      = 1'b0;
            raw_q           = 1'b0;
            stable_q        = 1'b0;
            change_age      = '0;
            toggle_age      = AGE_CEILING;
            open_q          = 1'b0;
            error_count     = 0;
            outstanding     = 0;
            results_checked = 0;
            toggles_seen    = 0;
        end
        else
        begin
            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dbts_pkg::REG_DEBOUNCE: debounce_len = cfg_data;
                    dbts_pkg::REG_LOCKOUT:  lockout_len  = cfg_data;
                    dbts_pkg::REG_OPEN:     open_deg     = cfg_data[7:0];
                    dbts_pkg::REG_CLOSED:   closed_deg   = cfg_data[7:0];
                    default: ;
                endcase
            end

            // Compare a result transfer against the oldest prediction
            if (out_valid && out_ready)
            begin
                got = '{position_open, duty_value, stable_pressed, toggled};
                results_checked++;
                if (expected_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("ERROR %0t: unpredicted result open=%0d duty=%0d %s%0d %s%0d",
                                 $realtime, got.position_open, got.duty_value,
                                 "stable=", got.stable_pressed,
                                 "toggled=", got.toggled);
                end
                else
                begin
                    want = expected_q.pop_front();
                    toggles_seen += want.toggled;
                    if (got.position_open !== want.position_open ||
                        got.duty_value !== want.duty_value ||
                        got.stable_pressed !== want.stable_pressed ||
                        got.toggled !== want.toggled)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                        begin
                            $write("ERROR %0t: result %0d open %0d/%0d duty %0d/%0d ",
                                   $realtime, results_checked,
                                   want.position_open, got.position_open,
                                   want.duty_value, got.duty_value);
                            $display("stable %0d/%0d toggled %0d/%0d (expected/actual)",
                                     want.stable_pressed, got.stable_pressed,
                                     want.toggled, got.toggled);
                        end
                    end
                end
            end

            // Predict the result of a sample transfer
            if (in_valid && in_ready)
                expected_q.push_back(step_servo(button_level));

            outstanding = expected_q.size();
        end
    end

endmodule

FILE: tb/debounced_toggle_servo_position_test.sv
// ----------------------------------------------------------------------------
// debounced_toggle_servo_position_test
// Drives button samples and register writes into the debounced toggle servo
// position block with random idling on both channels, and lets the checker
// judge every result. Covers priming, bounce filtering, lockout, angle
// clamping, and zero and full-scale register values.
// ----------------------------------------------------------------------------
module debounced_toggle_servo_position_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DUTY_BITS = 14;

    // Indexes that no register answers to, and the full-scale tick count
    localparam logic [dbts_pkg::CFG_INDEX_W-1:0] IDX_UNUSED = 8'd4;
    localparam logic [dbts_pkg::CFG_INDEX_W-1:0] IDX_TOP    = 8'hFF;
    localparam logic [15:0]                      TICKS_FULL = 16'hFFFF;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic                             button_level;
    logic                             out_valid;
    logic                             out_ready;
    logic                             position_open;
    logic [DUTY_BITS-1:0]             duty_value;
    logic                             stable_pressed;
    logic                             toggled;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [dbts_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [dbts_pkg::CFG_DATA_W-1:0]  cfg_data;

    int error_count;
    int outstanding;
    int results_checked;
    int toggles_seen;

    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_request;
    int          samples_sent;
    logic        last_level;
    logic [15:0] cur_debounce;
    logic [15:0] cur_lockout;

    debounced_toggle_servo_position #(.DUTY_BITS(DUTY_BITS)) dut (.*);

    servo_toggle_checker #(.DUTY_BITS(DUTY_BITS)) checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive result acceptance: random stalls plus an occasional long hold-off
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (!rst_n)
                out_ready = 1'b0;
            else if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Offer one sample and hold it until transferred
    task automatic send_sample(input logic level);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid     = 1'b1;
        button_level = level;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        samples_sent++;
        last_level = level;
    endtask

    task automatic write_reg(input logic [dbts_pkg::CFG_INDEX_W-1:0] index,
                             input logic [15:0] data);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (index == dbts_pkg::REG_DEBOUNCE)
            cur_debounce = data;
        else if (index == dbts_pkg::REG_LOCKOUT)
            cur_lockout = data;
    endtask

    // Stop offering samples until every result has come back
    task automatic settle();
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // Bounce, then hold the opposite level for a random stretch
    task automatic play_press_cycle();
        logic lvl;
        int   hold;
        lvl = ~last_level;
        repeat ($urandom_range(0, 3))
        begin
            send_sample(lvl);
            send_sample(~lvl);
        end
        if ($urandom_range(0, 7) == 0)
            hold = $urandom_range(0, int'(cur_debounce) + int'(cur_lockout) + 4);
        else
            hold = $urandom_range(0, int'(cur_debounce) + 3);
        repeat (hold + 1) send_sample(lvl);
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = samples_sent + count;
        while (samples_sent < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
                send_sample(1'($urandom_range(0, 1)));
            else
                play_press_cycle();
        end
    endtask

    task automatic write_angles_random();
        write_reg(dbts_pkg::REG_OPEN, 16'($urandom_range(0, 65535)));
        write_reg(dbts_pkg::REG_CLOSED, 16'($urandom_range(0, 65535)));
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        button_level  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        hold_request  = 0;
        samples_sent  = 0;
        last_level    = 1'b0;
        cur_debounce  = 16'd8;
        cur_lockout   = 16'd50;
        send_idle_pct = 7;
        recv_idle_pct = 47;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Priming press, then a release and a press through the reset debounce
        send_sample(1'b1);
        repeat (9) send_sample(1'b0);
        repeat (9) send_sample(1'b1);
        settle();

        // Zero debounce and lockout, clamped angles, ignored indexes
        write_reg(dbts_pkg::REG_DEBOUNCE, 16'h0000);
        write_reg(dbts_pkg::REG_LOCKOUT, 16'h0000);
        write_reg(dbts_pkg::REG_OPEN, 16'hFFFF);
        write_reg(dbts_pkg::REG_CLOSED, 16'h5AB4);
        write_reg(IDX_UNUSED, 16'hFFFF);
        write_reg(IDX_TOP, 16'hA5A5);
        send_sample(1'b0);
        send_sample(1'b1);
        send_sample(1'b0);
        send_sample(1'b1);
        settle();

        // Sender mostly busy, receiver stalls often
        write_reg(dbts_pkg::REG_DEBOUNCE, 16'd3);
        write_reg(dbts_pkg::REG_LOCKOUT, 16'd12);
        write_angles_random();
        run_random(400);
        settle();
        write_reg(dbts_pkg::REG_DEBOUNCE, 16'd0);
        write_reg(dbts_pkg::REG_LOCKOUT, 16'd0);
        write_angles_random();
        run_random(400);
        settle();

        // Sender gaps often, receiver mostly ready
        send_idle_pct = 47;
        recv_idle_pct = 7;
        write_reg(dbts_pkg::REG_DEBOUNCE, 16'($urandom_range(1, 6)));
        write_reg(dbts_pkg::REG_LOCKOUT, 16'($urandom_range(0, 30)));
        write_reg(dbts_pkg::REG_OPEN, 16'd180);
        write_reg(dbts_pkg::REG_CLOSED, 16'd0);
        run_random(400);
        settle();
        write_reg(dbts_pkg::REG_DEBOUNCE, 16'd2);
        write_reg(dbts_pkg::REG_LOCKOUT, 16'd8);
        write_angles_random();
        run_random(400);
        settle();

        // No idling; start with a long receiver hold-off to back up the block
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(dbts_pkg::REG_DEBOUNCE, 16'd2);
        write_reg(dbts_pkg::REG_LOCKOUT, 16'd5);
        write_angles_random();
        hold_request = 300;
        run_random(300);
        settle();

        // Full-scale debounce and lockout: the held press does not settle
        write_reg(dbts_pkg::REG_DEBOUNCE, 16'd0);
        write_reg(dbts_pkg::REG_LOCKOUT, 16'd0);
        send_sample(1'b0);
        send_sample(1'b0);
        settle();
        write_reg(dbts_pkg::REG_DEBOUNCE, TICKS_FULL);
        write_reg(dbts_pkg::REG_LOCKOUT, TICKS_FULL);
        repeat (40) send_sample(1'b1);
        settle();
        // Press again inside the lockout: no toggle
        write_reg(dbts_pkg::REG_DEBOUNCE, 16'd0);
        send_sample(1'b0);
        send_sample(1'b1);
        send_sample(1'b0);
        settle();

        repeat (10) @(posedge clk);
        $display("Run covered %0d samples and %0d checked results with %0d position toggles.",
                 samples_sent, results_checked, toggles_seen);
        $display("Debounce and lockout went from zero to full scale, angles up to 255 clamped.");
        if (error_count == 0 && outstanding == 0)
            $display("debounced_toggle_servo_position_test OK");
        else
            $display("debounced_toggle_servo_position_test NOT OK");
        $finish;
    end

    // Abort a hung run
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d results still outstanding", outstanding);
        $display("debounced_toggle_servo_position_test NOT OK");
        $finish;
    end

endmodule
